// ----- design/fvg_pkg.sv -----
// Package for the FAT volume geometry decoder: word types, status and kind codes,
// and the marker constants of the three FAT types. No dependencies.
package fvg_pkg;

   // Quotient width of the cluster divider: a 32-bit byte count shifted down
   // by at least nine bits leaves 23 significant bits.
   localparam int DIV_W      = 23;
   localparam int BASE_SHIFT = 9;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_SECTOR  = 3'd1;
   localparam logic [2:0] ST_CLUSTER = 3'd2;
   localparam logic [2:0] ST_FAT     = 3'd3;
   localparam logic [2:0] ST_TOTAL   = 3'd4;
   localparam logic [2:0] ST_ORDER   = 3'd5;
   localparam logic [2:0] ST_ACTIVE  = 3'd6;

   localparam logic [1:0] KIND_FAT12 = 2'd0;
   localparam logic [1:0] KIND_FAT16 = 2'd1;
   localparam logic [1:0] KIND_FAT32 = 2'd2;

   localparam logic [31:0] FAT12_LIMIT = 32'd4085;
   localparam logic [31:0] FAT16_LIMIT = 32'd65525;

   localparam logic [27:0] EOC_FAT12 = 28'h0000fff;
   localparam logic [27:0] BAD_FAT12 = 28'h0000ff7;
   localparam logic [27:0] EOC_FAT16 = 28'h000ffff;
   localparam logic [27:0] BAD_FAT16 = 28'h000fff7;
   localparam logic [27:0] EOC_FAT32 = 28'hfffffff;
   localparam logic [27:0] BAD_FAT32 = 28'hffffff7;

   localparam int MIRROR_OFF_BIT = 7;

   typedef struct packed {
      logic [15:0] sector_bytes;
      logic [7:0]  cluster_sectors;
      logic [15:0] reserved_sectors;
      logic [7:0]  fat_copies;
      logic [15:0] root_entries;
      logic [15:0] total_sectors_short;
      logic [31:0] total_sectors_long;
      logic [15:0] fat_sectors_short;
      logic [31:0] fat_sectors_long;
      logic [15:0] mirror_flags;
      logic [31:0] root_start_cluster;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [1:0]  fat_kind;
      logic [31:0] fat_offset;
      logic [31:0] fat_bytes;
      logic [31:0] root_offset;
      logic [20:0] root_bytes;
      logic [31:0] root_dir_cluster;
      logic [31:0] data_offset;
      logic [31:0] cluster_count;
      logic [27:0] end_chain_value;
      logic [27:0] bad_cluster_mark;
   } rsp_type;

   // Everything a word needs besides the cluster quotient, carried along the divider.
   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] fat_off;
      logic [31:0] fat_bytes;
      logic [31:0] root_off;
      logic [20:0] root_bytes;
      logic [31:0] data_off;
      logic [31:0] idx_prod;
      logic [7:0]  copies;
      logic        mirror_off;
      logic [3:0]  idx;
      logic [31:0] rclu;
      logic [7:0]  spc;
   } ctx_type;

   // Partial state of the restoring division handed from cell to cell.
   typedef struct packed {
      logic [7:0]       rem;
      logic [DIV_W-1:0] num;
      logic [DIV_W-1:0] quo;
   } div_type;

endpackage

// ----- design/fvg_div_cell.sv -----
// One cell of the cluster divider chain: develops one quotient bit per word.
// Depends on fvg_pkg.
module fvg_div_cell
   import fvg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  div_type in_div,
   input  ctx_type in_ctx,
   output logic    out_valid,
   output div_type out_div,
   output ctx_type out_ctx
);

   logic    valid_ff;
   div_type div_ff;
   div_type div_in;
   ctx_type ctx_ff;
   logic [8:0] trial;
   logic [8:0] divisor;
   logic [8:0] diff;
   logic       ge;

   always_comb begin
      trial   = {in_div.rem, in_div.num[DIV_W-1]};
      divisor = {1'b0, in_ctx.spc};
      diff    = trial - divisor;
      ge      = (trial >= divisor);
      div_in.rem = ge ? diff[7:0] : trial[7:0];
      div_in.num = {in_div.num[DIV_W-2:0], 1'b0};
      div_in.quo = {in_div.quo[DIV_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      div_ff <= div_in;
      ctx_ff <= in_ctx;
   end

   assign out_valid = valid_ff;
   assign out_div   = div_ff;
   assign out_ctx   = ctx_ff;

endmodule

// ----- design/fvg_prep.sv -----
// Front end of the decoder: field selection, sector-size shifts, FAT products,
// region offsets, the early checks and the divider's dividend. Depends on fvg_pkg.
module fvg_prep
   import fvg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  req_type in_req,
   output logic    out_valid,
   output div_type out_div,
   output ctx_type out_ctx
);

   typedef struct packed {
      logic [2:0]  status;
      logic [1:0]  sh;
      logic [31:0] fat_bytes;
      logic [31:0] fat_off;
      logic [20:0] root_bytes;
      logic [31:0] total_bytes;
      logic [7:0]  copies;
      logic        mirror_off;
      logic [3:0]  idx;
      logic [31:0] rclu;
      logic [7:0]  spc;
   } prep_type;

   logic     a_valid_ff, b_valid_ff, c_valid_ff;
   prep_type a_ff, a_in, b_ff;
   logic [31:0] b_prod_ff, b_prod_in;
   logic [31:0] b_idx_prod_ff, b_idx_prod_in;
   div_type  c_div_ff, c_div_in;
   ctx_type  c_ctx_ff, c_ctx_in;

   logic        sector_ok;
   logic [4:0]  a_shamt;
   logic [31:0] fs_sel;
   logic [31:0] total_sel;
   logic [4:0]  c_shamt;
   logic [31:0] root_off;
   logic [31:0] data_off;
   logic [31:0] data_size;
   logic [31:0] dividend;
   logic        order_bad;

   // First stage: sector sizes are powers of two, so every product by them is a shift.
   always_comb begin
      sector_ok = in_req.sector_bytes inside {16'd512, 16'd1024, 16'd2048, 16'd4096};
      case (in_req.sector_bytes)
         16'd1024: a_in.sh = 2'd1;
         16'd2048: a_in.sh = 2'd2;
         16'd4096: a_in.sh = 2'd3;
         default:  a_in.sh = 2'd0;
      endcase
      a_shamt   = 5'(BASE_SHIFT) + {3'd0, a_in.sh};
      fs_sel    = (in_req.fat_sectors_short != 16'd0) ?
                  {16'd0, in_req.fat_sectors_short} : in_req.fat_sectors_long;
      total_sel = (in_req.total_sectors_short != 16'd0) ?
                  {16'd0, in_req.total_sectors_short} : in_req.total_sectors_long;
      a_in.fat_bytes   = fs_sel << a_shamt;
      a_in.fat_off     = {16'd0, in_req.reserved_sectors} << a_shamt;
      a_in.root_bytes  = {in_req.root_entries, 5'd0};
      a_in.total_bytes = total_sel << a_shamt;
      a_in.copies      = in_req.fat_copies;
      a_in.mirror_off  = in_req.mirror_flags[MIRROR_OFF_BIT];
      a_in.idx         = in_req.mirror_flags[3:0];
      a_in.rclu        = in_req.root_start_cluster;
      a_in.spc         = in_req.cluster_sectors;
      if (!sector_ok) begin
         a_in.status = ST_SECTOR;
      end else if (in_req.cluster_sectors == 8'd0) begin
         a_in.status = ST_CLUSTER;
      end else if (a_in.fat_bytes == 32'd0) begin
         a_in.status = ST_FAT;
      end else if (total_sel == 32'd0) begin
         a_in.status = ST_TOTAL;
      end else begin
         a_in.status = ST_OK;
      end
   end

   // Second stage: the two FAT multiplications.
   always_comb begin
      b_prod_in     = a_ff.fat_bytes * {24'd0, a_ff.copies};
      b_idx_prod_in = a_ff.fat_bytes * {28'd0, a_ff.idx};
   end

   // Third stage: region offsets, the region order check and the dividend.
   always_comb begin
      c_shamt   = 5'(BASE_SHIFT) + {3'd0, b_ff.sh};
      root_off  = b_ff.fat_off + b_prod_ff;
      data_off  = root_off + {11'd0, b_ff.root_bytes};
      data_size = b_ff.total_bytes - data_off;
      dividend  = data_size >> c_shamt;
      order_bad = (b_ff.fat_off >= root_off) || (root_off > data_off);

      c_div_in.rem = 8'd0;
      c_div_in.num = dividend[DIV_W-1:0];
      c_div_in.quo = '0;

      c_ctx_in.status     = (b_ff.status != ST_OK) ? b_ff.status :
                            (order_bad ? ST_ORDER : ST_OK);
      c_ctx_in.fat_off    = b_ff.fat_off;
      c_ctx_in.fat_bytes  = b_ff.fat_bytes;
      c_ctx_in.root_off   = root_off;
      c_ctx_in.root_bytes = b_ff.root_bytes;
      c_ctx_in.data_off   = data_off;
      c_ctx_in.idx_prod   = b_idx_prod_ff;
      c_ctx_in.copies     = b_ff.copies;
      c_ctx_in.mirror_off = b_ff.mirror_off;
      c_ctx_in.idx        = b_ff.idx;
      c_ctx_in.rclu       = b_ff.rclu;
      c_ctx_in.spc        = b_ff.spc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
      a_ff          <= a_in;
      b_ff          <= a_ff;
      b_prod_ff     <= b_prod_in;
      b_idx_prod_ff <= b_idx_prod_in;
      c_div_ff      <= c_div_in;
      c_ctx_ff      <= c_ctx_in;
   end

   assign out_valid = c_valid_ff;
   assign out_div   = c_div_ff;
   assign out_ctx   = c_ctx_ff;

endmodule

// ----- design/fvg_finish.sv -----
// Back end of the decoder: FAT type by cluster count, active FAT selection,
// the last check and the registered result word. Depends on fvg_pkg.
module fvg_finish
   import fvg_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  ctx_type          in_ctx,
   input  logic [DIV_W-1:0] in_quo,
   output logic             out_strobe,
   output rsp_type          out_rsp
);

   logic    strobe_ff;
   rsp_type rsp_ff, rsp_in;
   logic [31:0] clusters;
   logic        is_fat32;
   logic        use_idx;
   logic [2:0]  status;

   always_comb begin
      clusters = {{(32 - DIV_W){1'b0}}, in_quo};
      is_fat32 = (clusters >= FAT16_LIMIT);
      use_idx  = is_fat32 && in_ctx.mirror_off;

      if (in_ctx.status != ST_OK) begin
         status = in_ctx.status;
      end else if (use_idx && ({4'd0, in_ctx.idx} >= in_ctx.copies)) begin
         status = ST_ACTIVE;
      end else begin
         status = ST_OK;
      end

      rsp_in = '0;
      rsp_in.status = status;
      if (status == ST_OK) begin
         if (clusters < FAT12_LIMIT) begin
            rsp_in.fat_kind         = KIND_FAT12;
            rsp_in.end_chain_value  = EOC_FAT12;
            rsp_in.bad_cluster_mark = BAD_FAT12;
         end else if (!is_fat32) begin
            rsp_in.fat_kind         = KIND_FAT16;
            rsp_in.end_chain_value  = EOC_FAT16;
            rsp_in.bad_cluster_mark = BAD_FAT16;
         end else begin
            rsp_in.fat_kind         = KIND_FAT32;
            rsp_in.end_chain_value  = EOC_FAT32;
            rsp_in.bad_cluster_mark = BAD_FAT32;
            rsp_in.root_dir_cluster = in_ctx.rclu;
         end
         rsp_in.fat_offset    = in_ctx.fat_off + (use_idx ? in_ctx.idx_prod : 32'd0);
         rsp_in.fat_bytes     = in_ctx.fat_bytes;
         rsp_in.root_offset   = in_ctx.root_off;
         rsp_in.root_bytes    = in_ctx.root_bytes;
         rsp_in.data_offset   = in_ctx.data_off;
         rsp_in.cluster_count = clusters;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= in_valid;
      end
      rsp_ff <= rsp_in;
   end

   assign out_strobe = strobe_ff;
   assign out_rsp    = rsp_ff;

endmodule

// ----- design/fat_volume_geometry_decoder_core.sv -----
// Top level of the FAT volume geometry decoder: front end, divider cell chain
// and result stage. Depends on fvg_pkg, fvg_prep, fvg_div_cell and fvg_finish.
//
// Use: drive the boot-sector fields on req_data and raise start. A word is
// taken at every rising edge where start is high and busy is low. The block
// answers each word with one result word on rsp_data, marked by rsp_strobe
// for exactly one cycle; results leave in the order the words came in.
// Between the accepting edge and the strobe lie three front-end stages, one
// cell per quotient bit of the 23-bit cluster divider, and the output
// register. Throughput is one word per cycle while busy is low, set by the
// divider chain, whose cells each hand their partial remainder to the next
// cell on every edge.
// Reset clears every valid flag in the pipeline and holds busy high; busy
// drops in the cycle after reset is released and then stays low.
// The receiver cannot stall: every result is shown once and must be taken.
module fat_volume_geometry_decoder_core
   import fvg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   logic    busy_ff;
   logic    accept;
   logic    chain_valid [0:DIV_W];
   div_type chain_div   [0:DIV_W];
   ctx_type chain_ctx   [0:DIV_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   fvg_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_req    (req_data),
      .out_valid (chain_valid[0]),
      .out_div   (chain_div[0]),
      .out_ctx   (chain_ctx[0])
   );

   for (genvar i = 0; i < DIV_W; i++) begin : g_cell
      fvg_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_div    (chain_div[i]),
         .in_ctx    (chain_ctx[i]),
         .out_valid (chain_valid[i+1]),
         .out_div   (chain_div[i+1]),
         .out_ctx   (chain_ctx[i+1])
      );
   end

   fvg_finish u_finish (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (chain_valid[DIV_W]),
      .in_ctx     (chain_ctx[DIV_W]),
      .in_quo     (chain_div[DIV_W].quo),
      .out_strobe (rsp_strobe),
      .out_rsp    (rsp_data)
   );

endmodule
